// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/apsp_pkg.sv -----
// ----------------------------------------------------------------------------
// apsp_pkg
// shared types and constants of the shortest path engine
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int MAX_NODES     = 64;
    localparam int NODE_BITS     = $clog2(MAX_NODES);
    localparam int ADDR_BITS     = 2 * NODE_BITS;
    localparam int MAT_DEPTH     = MAX_NODES * MAX_NODES;
    localparam int DIST_BITS     = 40;
    localparam int OUT_BITS      = 40;
    localparam int WEIGHT_BITS   = 32;
    localparam int NODE_CNT_BITS = 7;
    localparam int FIELD_NODE_W  = 6;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 48;
    localparam int S_TUSER_W     = 2;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;
    localparam logic [NODE_CNT_BITS-1:0] NODE_CNT_RESET = NODE_CNT_BITS'(64);
    localparam logic [NODE_CNT_BITS-1:0] NODE_CNT_MAX = NODE_CNT_BITS'(MAX_NODES);

    // output tdata bit positions
    localparam int M_REACH_BIT = 0;
    localparam int M_DIST_LO   = 1;
    localparam int M_DIST_HI   = M_DIST_LO + OUT_BITS - 1;

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef struct packed {
        logic                 lower;
        logic [DIST_BITS-1:0] cand;
    } t_relax_res;

endpackage

// ----- rtl/all_pairs_shortest_path_engine_core.sv -----
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_engine_core
// floyd-warshall engine over a 64 x 64 distance matrix
// ----------------------------------------------------------------------------
// The block holds a 4096-entry distance matrix in one memory with two read
// ports and one write port, and does all arithmetic in a single shared
// saturating add-and-compare unit driven by a sequencer; it takes one
// transaction at a time and drops tready while working. After reset, and on
// every clear transaction, a clearing pass writes infinity to all 4096
// entries, one entry per cycle. An edge transaction reads the (a, b) and
// (b, a) entries and writes the weight into each that it lowers; a query
// reads (a, b) and waits for the result register to be taken. A solve over
// n nodes zeroes the diagonal, then for each (k, i) pair reads (i, k) and,
// if it is finite, for each j writes (i, k) + (k, j) into (i, j) where it
// is lower. node_count may be written at any idle time.
module all_pairs_shortest_path_engine_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [apsp_pkg::NODE_CNT_BITS-1:0]    i_cfg_data,
    // request stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // node_a [5:0], node_b [11:6], edge_weight [43:12], zero pad
    input  logic [apsp_pkg::S_TDATA_W-1:0]        i_s_axis_tdata,
    // req_type [1:0]
    input  logic [apsp_pkg::S_TUSER_W-1:0]        i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // reachable [0], distance [40:1], zero pad
    output logic [apsp_pkg::M_TDATA_W-1:0]        o_m_axis_tdata
);

    localparam int NB = apsp_pkg::NODE_BITS;
    localparam int AB = apsp_pkg::ADDR_BITS;
    localparam int DB = apsp_pkg::DIST_BITS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_AB,
        S_EDGE_BA,
        S_QUERY,
        S_DIAG,
        S_RD_IK,
        S_CHK_IK,
        S_RD_J,
        S_WR_J
    } t_state;

    t_state                           r_state, n_state;
    logic [NB-1:0]                    r_k, n_k;
    logic [NB-1:0]                    r_i, n_i;
    logic [NB-1:0]                    r_j, n_j;
    logic [NB-1:0]                    r_last, n_last;
    logic [NB-1:0]                    r_a, n_a;
    logic [NB-1:0]                    r_b, n_b;
    logic [DB-1:0]                    r_ik, n_ik;
    logic [DB-1:0]                    r_w, n_w;
    logic [AB-1:0]                    r_clr, n_clr;
    logic [apsp_pkg::NODE_CNT_BITS-1:0] r_node_count;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_reach, n_out_reach;
    logic [apsp_pkg::OUT_BITS-1:0]    r_out_dist, n_out_dist;

    logic                             ram_we;
    logic [AB-1:0]                    ram_waddr;
    logic [DB-1:0]                    ram_wdata;
    logic                             ram_re;
    logic [AB-1:0]                    ram_raddr0;
    logic [AB-1:0]                    ram_raddr1;
    logic [DB-1:0]                    ram_rdata0;
    logic [DB-1:0]                    ram_rdata1;

    logic [DB-1:0]                    relax_base;
    logic [DB-1:0]                    relax_step;
    logic [DB-1:0]                    relax_cur;
    apsp_pkg::t_relax_res             relax_res;

    logic                             s_accept;
    apsp_pkg::t_req                   req;
    logic [NB-1:0]                    in_a;
    logic [NB-1:0]                    in_b;
    logic [apsp_pkg::WEIGHT_BITS-1:0] in_w;
    logic [apsp_pkg::NODE_CNT_BITS-1:0] n_eff;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign req             = apsp_pkg::t_req'(i_s_axis_tuser);
    assign in_a            = i_s_axis_tdata[NB-1:0];
    assign in_b            = i_s_axis_tdata[2*apsp_pkg::FIELD_NODE_W-1:apsp_pkg::FIELD_NODE_W];
    assign in_w            = i_s_axis_tdata[2*apsp_pkg::FIELD_NODE_W +: apsp_pkg::WEIGHT_BITS];
    assign n_eff           = (r_node_count > apsp_pkg::NODE_CNT_MAX) ?
                             apsp_pkg::NODE_CNT_MAX : r_node_count;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(apsp_pkg::M_TDATA_W - apsp_pkg::OUT_BITS - 1)'(0),
                              r_out_dist, r_out_reach};

    apsp_dist_ram #(
        .ADDR_W (AB),
        .DATA_W (DB)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re     (ram_re),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    always_comb begin
        relax_base = (r_state == S_WR_J) ? r_ik : r_w;
        relax_step = (r_state == S_WR_J) ? ram_rdata0 : '0;
        relax_cur  = (r_state == S_EDGE_AB) ? ram_rdata0 : ram_rdata1;
    end

    apsp_relax_unit u_relax (
        .i_base (relax_base),
        .i_step (relax_step),
        .i_cur  (relax_cur),
        .o_res  (relax_res)
    );

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_last      = r_last;
        n_a         = r_a;
        n_b         = r_b;
        n_ik        = r_ik;
        n_w         = r_w;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_reach = r_out_reach;
        n_out_dist  = r_out_dist;
        ram_we      = 1'b0;
        ram_waddr   = {r_i, r_j};
        ram_wdata   = relax_res.cand;
        ram_re      = 1'b0;
        ram_raddr0  = {in_a, in_b};
        ram_raddr1  = {in_b, in_a};

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = apsp_pkg::DIST_INF;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_a = in_a;
                    n_b = in_b;
                    n_w = DB'(in_w);
                    case (req)
                        apsp_pkg::REQ_EDGE: begin
                            ram_re  = 1'b1;
                            n_state = S_EDGE_AB;
                        end
                        apsp_pkg::REQ_SOLVE: begin
                            n_i    = '0;
                            n_last = NB'(n_eff - 1'b1);
                            if (n_eff != '0) begin
                                n_state = S_DIAG;
                            end
                        end
                        apsp_pkg::REQ_QUERY: begin
                            ram_re  = 1'b1;
                            n_state = S_QUERY;
                        end
                        default: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_EDGE_AB: begin
                ram_we    = relax_res.lower;
                ram_waddr = {r_a, r_b};
                n_state   = S_EDGE_BA;
            end
            S_EDGE_BA: begin
                ram_we    = relax_res.lower;
                ram_waddr = {r_b, r_a};
                n_state   = S_IDLE;
            end
            S_QUERY: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_reach = (ram_rdata0 != apsp_pkg::DIST_INF);
                    n_out_dist  = (ram_rdata0 != apsp_pkg::DIST_INF) ?
                                  ram_rdata0[apsp_pkg::OUT_BITS-1:0] : '0;
                    n_state     = S_IDLE;
                end
            end
            S_DIAG: begin
                ram_we    = 1'b1;
                ram_waddr = {r_i, r_i};
                ram_wdata = '0;
                n_i       = r_i + 1'b1;
                if (r_i == r_last) begin
                    n_i     = '0;
                    n_k     = '0;
                    n_state = S_RD_IK;
                end
            end
            S_RD_IK: begin
                ram_re     = 1'b1;
                ram_raddr0 = {r_i, r_k};
                n_state    = S_CHK_IK;
            end
            S_CHK_IK: begin
                n_ik = ram_rdata0;
                n_j  = '0;
                if (ram_rdata0 != apsp_pkg::DIST_INF) begin
                    n_state = S_RD_J;
                end else if (r_i != r_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RD_IK;
                end else if (r_k != r_last) begin
                    n_i     = '0;
                    n_k     = r_k + 1'b1;
                    n_state = S_RD_IK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD_J: begin
                ram_re     = 1'b1;
                ram_raddr0 = {r_k, r_j};
                ram_raddr1 = {r_i, r_j};
                n_state    = S_WR_J;
            end
            S_WR_J: begin
                ram_we    = relax_res.lower;
                ram_waddr = {r_i, r_j};
                n_j       = r_j + 1'b1;
                if (r_j != r_last) begin
                    n_state = S_RD_J;
                end else if (r_i != r_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_RD_IK;
                end else if (r_k != r_last) begin
                    n_i     = '0;
                    n_k     = r_k + 1'b1;
                    n_state = S_RD_IK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= apsp_pkg::NODE_CNT_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
        r_k         <= n_k;
        r_i         <= n_i;
        r_j         <= n_j;
        r_last      <= n_last;
        r_a         <= n_a;
        r_b         <= n_b;
        r_ik        <= n_ik;
        r_w         <= n_w;
        r_out_reach <= n_out_reach;
        r_out_dist  <= n_out_dist;
    end

endmodule

// ----- rtl/apsp_dist_ram.sv -----
// ----------------------------------------------------------------------------
// apsp_dist_ram
// distance matrix store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module apsp_dist_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr0,
    input  logic [ADDR_W-1:0] i_raddr1,
    output logic [DATA_W-1:0] o_rdata0,
    output logic [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// ----- rtl/apsp_relax_unit.sv -----
// ----------------------------------------------------------------------------
// apsp_relax_unit
// saturating add of two distances and compare against the current entry
// ----------------------------------------------------------------------------
module apsp_relax_unit (
    input  logic [apsp_pkg::DIST_BITS-1:0] i_base,
    input  logic [apsp_pkg::DIST_BITS-1:0] i_step,
    input  logic [apsp_pkg::DIST_BITS-1:0] i_cur,
    output apsp_pkg::t_relax_res           o_res
);

    logic [apsp_pkg::DIST_BITS:0]   sum;
    logic [apsp_pkg::DIST_BITS-1:0] cand;

    always_comb begin
        sum = {1'b0, i_base} + {1'b0, i_step};
        if (i_base == apsp_pkg::DIST_INF || i_step == apsp_pkg::DIST_INF ||
            sum >= {1'b0, apsp_pkg::DIST_INF}) begin
            cand = apsp_pkg::DIST_INF;
        end else begin
            cand = sum[apsp_pkg::DIST_BITS-1:0];
        end
        o_res.cand  = cand;
        o_res.lower = (cand < i_cur);
    end

endmodule

// ----- rtl/apsp_checker.sv -----
// ----------------------------------------------------------------------------
// apsp_checker
// port-level checks of the shortest path engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [apsp_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [apsp_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    logic s_acc;
    logic q_acc;
    logic q_fresh;
    logic m_stall;
    logic m_unreach;
    logic m_dist_zero;

    assign s_acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign q_acc       = s_acc && (i_s_axis_tuser == apsp_pkg::REQ_QUERY);
    assign q_fresh     = q_acc && !o_m_axis_tvalid;
    assign m_stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_unreach   = o_m_axis_tvalid && !o_m_axis_tdata[apsp_pkg::M_REACH_BIT];
    assign m_dist_zero = (o_m_axis_tdata[apsp_pkg::M_DIST_HI:apsp_pkg::M_DIST_LO] == '0);

    // stalled result transaction stays offered
    `ASSERT_NXT(a_m_hold, i_clk, i_rst_n, m_stall, o_m_axis_tvalid)

    // unreachable results carry a zero distance
    `ASSERT_IMP(a_unreach_zero, i_clk, i_rst_n, m_unreach, m_dist_zero)

    // a query into an empty result slot passes through S_QUERY and then raises the result valid
    `ASSERT_NXT(a_query_lat, i_clk, i_rst_n, $past(q_fresh), o_m_axis_tvalid)

    // clearing pass after reset holds off requests
    `ASSERT_IMP(a_reset_busy, i_clk, i_rst_n, $past(!i_rst_n), !o_s_axis_tready)

endmodule

bind all_pairs_shortest_path_engine_core apsp_checker u_apsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
